### rtl/core/sstfa_pkg.sv
// Package for the scoped symbol table and frame allocator.
// Holds operation and status codes, size limits and the type size table.
// No dependencies.
`timescale 1ns / 1ps

package sstfa_pkg;

    // Default sizing of the table and of the stored names.
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int NAME_BYTES_DEF    = 8;

    // Operation codes carried by a request.
    localparam logic [2:0] MODE_LOCAL       = 3'd0;
    localparam logic [2:0] MODE_GLOBAL      = 3'd1;
    localparam logic [2:0] MODE_FIND        = 3'd2;
    localparam logic [2:0] MODE_SCOPE_BEGIN = 3'd3;
    localparam logic [2:0] MODE_SCOPE_END   = 3'd4;

    // Status codes returned with every result.
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_DUP      = 3'd1;
    localparam logic [2:0] STAT_FULL     = 3'd2;
    localparam logic [2:0] STAT_NOTFOUND = 3'd3;
    localparam logic [2:0] STAT_OVERFLOW = 3'd4;

    // Type codes with a size of their own.
    localparam logic [2:0] TYPE_CHAR   = 3'd0;
    localparam logic [2:0] TYPE_INT    = 3'd1;
    localparam logic [2:0] TYPE_FLOAT  = 3'd2;
    localparam logic [2:0] TYPE_BOOL   = 3'd3;
    localparam logic [2:0] TYPE_INT64  = 3'd4;
    localparam logic [2:0] TYPE_STRING = 3'd5;

    // Lowest legal frame offset and largest frame in bytes.
    localparam int OFF_MIN   = -1048576;
    localparam int FRAME_MAX = 1048576;

    // Byte size of each type; other codes take no space.
    function automatic logic [15:0] type_size(input logic [2:0] t);
        logic [15:0] s;
        case (t)
            TYPE_CHAR:   s = 16'd1;
            TYPE_INT:    s = 16'd4;
            TYPE_FLOAT:  s = 16'd4;
            TYPE_BOOL:   s = 16'd1;
            TYPE_INT64:  s = 16'd8;
            TYPE_STRING: s = 16'd16;
            default:     s = 16'd0;
        endcase
        return s;
    endfunction

endpackage

### rtl/core/sstfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sstfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read data holds its value while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/scoped_symbol_table_frame_allocator.sv
// Top level of the scoped symbol table with a downward-growing frame allocator.
// Depends on sstfa_pkg and sstfa_ram.
`timescale 1ns / 1ps

// Channel     Direction  Handshake                 Payload
// ----------  ---------  ------------------------  -------------------------------------------
// request     in         start high, busy low      i_mode, i_name_bytes, i_name_len,
//                                                  i_data_type, i_size_request, i_scope_mark
// result      out        o_valid, one cycle        o_status, o_frame_offset, o_found_type,
//                                                  o_found_size, o_is_global_sym,
//                                                  o_label_number, o_entry_count, o_frame_bytes
// config      in         i_cfg_we                  i_cfg_wdata (initial frame offset)
//
// Declare and find requests scan the table one entry per cycle through the single read
// port of the entry RAM. A request is latched in S_IDLE, scanned in S_SCAN (which ends
// early when a matching name is met), carried out in S_EXEC and reported from S_REPORT;
// scope begin, scope end and unknown codes skip S_SCAN. A new request may be accepted in
// the cycle in which the previous result is shown. Reset is synchronous and active low;
// it empties the table and clears the frame, and needs no pass over the RAM, since only
// entries below the entry count are ever read. The receiver cannot stall: each result is
// valid for exactly one cycle.

module scoped_symbol_table_frame_allocator #(
    parameter int TABLE_ENTRIES = sstfa_pkg::TABLE_ENTRIES_DEF,
    parameter int NAME_BYTES    = sstfa_pkg::NAME_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Request channel
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_mode,
    input  logic [63:0]        i_name_bytes,
    input  logic [3:0]         i_name_len,
    input  logic [2:0]         i_data_type,
    input  logic [15:0]        i_size_request,
    input  logic [6:0]         i_scope_mark,
    // Configuration
    input  logic               i_cfg_we,
    input  logic signed [15:0] i_cfg_wdata,
    // Result channel
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic signed [20:0] o_frame_offset,
    output logic [2:0]         o_found_type,
    output logic [15:0]        o_found_size,
    output logic               o_is_global_sym,
    output logic [6:0]         o_label_number,
    output logic [6:0]         o_entry_count,
    output logic [20:0]        o_frame_bytes
);

    import sstfa_pkg::*;

    localparam int AW     = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
    localparam int NAME_W = NAME_BYTES * 8;

    // Layout of one RAM word: {name, length, offset, type, size, label, global}.
    localparam int P_GLOB  = 0;
    localparam int P_LABEL = 1;
    localparam int P_SIZE  = 8;
    localparam int P_TYPE  = 24;
    localparam int P_OFF   = 27;
    localparam int P_LEN   = 48;
    localparam int P_NAME  = 52;
    localparam int ENT_W   = P_NAME + NAME_W;

    localparam logic signed [22:0] OFF_LIMIT  = 23'(OFF_MIN);
    localparam logic signed [23:0] SPAN_LIMIT = 24'(FRAME_MAX);
    localparam logic [23:0]        FRAME_CAP  = 24'(FRAME_MAX);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_EXEC   = 4'b0100,
        S_REPORT = 4'b1000
    } t_state;

    // Control state.
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_addr, n_addr;
    logic               r_pend, n_pend;
    logic               r_found, n_found;
    logic [CNT_W-1:0]   r_used, n_used;
    logic signed [20:0] r_cur, n_cur;
    logic signed [15:0] r_init;
    logic [6:0]         r_label, n_label;
    logic               r_valid, n_valid;

    // Latched request.
    logic [2:0]         r_mode, n_mode;
    logic [NAME_W-1:0]  r_name, n_name;
    logic [3:0]         r_len, n_len;
    logic [2:0]         r_type, n_type;
    logic [15:0]        r_bytes, n_bytes;
    logic [16:0]        r_round, n_round;
    logic [6:0]         r_mark, n_mark;

    // Result payload.
    logic [2:0]         r_status, n_status;
    logic signed [20:0] r_off, n_off;
    logic [2:0]         r_ftype, n_ftype;
    logic [15:0]        r_fsize, n_fsize;
    logic               r_glob, n_glob;
    logic [6:0]         r_lab_out, n_lab_out;
    logic [6:0]         r_count, n_count;
    logic [20:0]        r_frame, n_frame;

    // Request decode.
    logic [3:0]         key_len;
    logic [NAME_W-1:0]  key_name;
    logic [15:0]        key_bytes;

    // RAM access.
    logic               ram_we;
    logic               ram_re;
    logic [ENT_W-1:0]   ram_wdata;
    logic [ENT_W-1:0]   ram_rdata;

    logic [NAME_W-1:0]  rd_name;
    logic [3:0]         rd_len;
    logic signed [20:0] rd_off;
    logic [2:0]         rd_type;
    logic [15:0]        rd_size;
    logic [6:0]         rd_label;
    logic               rd_glob;
    logic               rd_match;

    // Frame arithmetic.
    logic signed [22:0] new_off;
    logic signed [23:0] new_span;
    logic               frame_ovf;
    logic               table_full;
    logic signed [23:0] used_span;
    logic [23:0]        used_round;

    assign busy = (r_state != S_IDLE);

    // A name length beyond the stored width is clipped, and bytes past the
    // length are cleared so that names compare as whole words.
    always_comb begin
        key_len = (i_name_len > 4'(NAME_BYTES)) ? 4'(NAME_BYTES) : i_name_len;
        for (int b = 0; b < NAME_BYTES; b++) begin
            key_name[b*8 +: 8] = (4'(b) < key_len) ? i_name_bytes[b*8 +: 8] : 8'h00;
        end
        key_bytes = (i_size_request != 16'd0) ? i_size_request : type_size(i_data_type);
    end

    assign rd_glob  = ram_rdata[P_GLOB];
    assign rd_label = ram_rdata[P_SIZE-1:P_LABEL];
    assign rd_size  = ram_rdata[P_TYPE-1:P_SIZE];
    assign rd_type  = ram_rdata[P_OFF-1:P_TYPE];
    assign rd_off   = $signed(ram_rdata[P_LEN-1:P_OFF]);
    assign rd_len   = ram_rdata[P_NAME-1:P_LEN];
    assign rd_name  = ram_rdata[ENT_W-1:P_NAME];

    // The read data of the previous scan cycle is compared against the key.
    assign rd_match = r_pend && (r_state == S_SCAN) && (rd_len == r_len)
                      && (rd_name == r_name);

    // A local moves the frame down by its size rounded up to eight; the move
    // is refused when the offset or the frame span would leave its range.
    assign new_off    = 23'(r_cur) - $signed({6'd0, r_round});
    assign new_span   = 24'(r_init) - 24'(new_off);
    assign frame_ovf  = (new_off < OFF_LIMIT) || (new_span > SPAN_LIMIT);
    assign table_full = (r_used >= CNT_W'(TABLE_ENTRIES));

    // Frame bytes in use: floored at zero, rounded up to sixteen, saturated.
    assign used_span  = 24'(r_init) - 24'(r_cur);
    assign used_round = (24'(used_span) + 24'd15) & ~24'd15;

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_pend    = r_pend;
        n_found   = r_found;
        n_used    = r_used;
        n_cur     = r_cur;
        n_label   = r_label;
        n_valid   = 1'b0;
        n_mode    = r_mode;
        n_name    = r_name;
        n_len     = r_len;
        n_type    = r_type;
        n_bytes   = r_bytes;
        n_round   = r_round;
        n_mark    = r_mark;
        n_status  = r_status;
        n_off     = r_off;
        n_ftype   = r_ftype;
        n_fsize   = r_fsize;
        n_glob    = r_glob;
        n_lab_out = r_lab_out;
        n_count   = r_count;
        n_frame   = r_frame;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_wdata = {r_name, r_len, 21'sd0, r_type, r_bytes, 7'd0, 1'b0};

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_mode  = i_mode;
                    n_name  = key_name;
                    n_len   = key_len;
                    n_type  = i_data_type;
                    n_bytes = key_bytes;
                    n_round = ({1'b0, key_bytes} + 17'd7) & ~17'd7;
                    n_mark  = i_scope_mark;
                    n_addr  = '0;
                    n_pend  = 1'b0;
                    n_found = 1'b0;
                    unique case (i_mode) inside
                        MODE_LOCAL, MODE_GLOBAL, MODE_FIND: n_state = S_SCAN;
                        default:                            n_state = S_EXEC;
                    endcase
                end
            end

            S_SCAN: begin
                n_pend = 1'b0;
                if (rd_match) begin
                    n_found = 1'b1;
                    n_state = S_EXEC;
                end else if (r_addr >= r_used) begin
                    n_state = S_EXEC;
                end else begin
                    ram_re = 1'b1;
                    n_addr = r_addr + CNT_W'(1);
                    n_pend = 1'b1;
                end
            end

            S_EXEC: begin
                n_status  = STAT_OK;
                n_off     = '0;
                n_ftype   = '0;
                n_fsize   = '0;
                n_glob    = 1'b0;
                n_lab_out = '0;
                n_state   = S_REPORT;
                unique case (r_mode)
                    MODE_LOCAL: begin
                        if (r_found) begin
                            n_status = STAT_DUP;
                        end else if (table_full) begin
                            n_status = STAT_FULL;
                        end else if (frame_ovf) begin
                            n_status = STAT_OVERFLOW;
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = {r_name, r_len, 21'(new_off), r_type, r_bytes,
                                         7'd0, 1'b0};
                            n_cur     = 21'(new_off);
                            n_used    = r_used + CNT_W'(1);
                            n_off     = 21'(new_off);
                            n_ftype   = r_type;
                            n_fsize   = r_bytes;
                        end
                    end
                    MODE_GLOBAL: begin
                        if (r_found) begin
                            n_status = STAT_DUP;
                        end else if (table_full) begin
                            n_status = STAT_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = {r_name, r_len, 21'sd0, r_type, r_bytes,
                                         r_label, 1'b1};
                            n_label   = r_label + 7'd1;
                            n_used    = r_used + CNT_W'(1);
                            n_ftype   = r_type;
                            n_fsize   = r_bytes;
                            n_glob    = 1'b1;
                            n_lab_out = r_label;
                        end
                    end
                    MODE_FIND: begin
                        if (r_found) begin
                            n_off     = rd_off;
                            n_ftype   = rd_type;
                            n_fsize   = rd_size;
                            n_glob    = rd_glob;
                            n_lab_out = rd_label;
                        end else begin
                            n_status = STAT_NOTFOUND;
                            n_ftype  = TYPE_INT64;
                        end
                    end
                    MODE_SCOPE_BEGIN: begin
                        n_cur = 21'(r_init);
                    end
                    MODE_SCOPE_END: begin
                        // A mark beyond the current count leaves the table as it is.
                        if (CMP_W'(r_mark) <= CMP_W'(r_used)) begin
                            n_used = CNT_W'(r_mark);
                        end
                        n_cur = 21'(r_init);
                    end
                    default: begin
                    end
                endcase
            end

            S_REPORT: begin
                n_count = 7'(r_used);
                if (used_span < 24'sd0) begin
                    n_frame = '0;
                end else if (used_round > FRAME_CAP) begin
                    n_frame = 21'(FRAME_CAP);
                end else begin
                    n_frame = 21'(used_round);
                end
                n_valid = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_used  <= '0;
            r_cur   <= '0;
            r_init  <= '0;
            r_label <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_pend  <= n_pend;
            r_found <= n_found;
            r_used  <= n_used;
            r_cur   <= n_cur;
            r_label <= n_label;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_init <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_name    <= n_name;
        r_len     <= n_len;
        r_type    <= n_type;
        r_bytes   <= n_bytes;
        r_round   <= n_round;
        r_mark    <= n_mark;
        r_status  <= n_status;
        r_off     <= n_off;
        r_ftype   <= n_ftype;
        r_fsize   <= n_fsize;
        r_glob    <= n_glob;
        r_lab_out <= n_lab_out;
        r_count   <= n_count;
        r_frame   <= n_frame;
    end

    // All entry fields live in one RAM word; scans read the port at the scan
    // address, and a declaration appends at the entry count.
    sstfa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_used[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_frame_offset  = r_off;
    assign o_found_type    = r_ftype;
    assign o_found_size    = r_fsize;
    assign o_is_global_sym = r_glob;
    assign o_label_number  = r_lab_out;
    assign o_entry_count   = r_count;
    assign o_frame_bytes   = r_frame;

    // The table is only written once the scan has ruled out a duplicate.
    a_write_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_EXEC) && !r_found && !table_full)
        else $error("entry RAM written outside a completed declaration");

    // Scan reads never run past the entries in use.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> (r_addr < r_used))
        else $error("scan read beyond the entry count");

    // The entry count stays within the table.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count exceeds table depth");

    // A result strobe follows the report cycle and nothing else.
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(r_state == S_REPORT))
        else $error("result strobe without a report cycle");

    // An accepted request keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without entering work");

endmodule
